// ===== hw/rtl/tss_pkg.sv =====
package tss_pkg;

   localparam int TASK_SLOTS_DEF = 16;
   localparam int SEM_COUNT_DEF  = 8;

   typedef enum logic [2:0] {
      FUNC_SAVE     = 3'd0,
      FUNC_SWITCH   = 3'd1,
      FUNC_CREATE   = 3'd2,
      FUNC_TEARDOWN = 3'd3,
      FUNC_SEM_SET  = 3'd4,
      FUNC_SEM_TAKE = 3'd5,
      FUNC_SEM_GIVE = 3'd6
   } func_type;

   typedef enum logic [2:0] {
      ST_RUNNABLE      = 3'd0,
      ST_RUNNING       = 3'd1,
      ST_WAITING_TOBE  = 3'd2,
      ST_WAITING       = 3'd3,
      ST_RUNNABLE_TOBE = 3'd4,
      ST_KILLED        = 3'd5
   } task_state_type;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NONE     = 2'd1;
   localparam logic [1:0] STATUS_BAD      = 2'd2;

   localparam logic signed [15:0] COUNT_MAX = 16'sh7fff;
   localparam logic signed [15:0] COUNT_MIN = -16'sh8000;

   typedef struct packed {
      logic [2:0] func;
      logic [3:0] task_slot;
      logic [2:0] sem_id;
      logic [7:0] init_count;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] slot;
      logic       idle;
      logic       blocked;
      logic       freed;
   } rsp_type;

   // scan unit control
   typedef struct packed {
      logic start;
      logic done;
      logic found;
   } scan_ctl_type;

endpackage

// ===== hw/rtl/tss_scan.sv =====
module tss_scan #(
   parameter int TASK_SLOTS = tss_pkg::TASK_SLOTS_DEF,
   localparam int IW = $clog2(TASK_SLOTS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [IW-1:0]         first,
   input  logic [TASK_SLOTS-1:0] hit,
   output tss_pkg::scan_ctl_type ctl,
   output logic [IW-1:0]         index
);

   logic            busy_ff, busy_in;
   logic [IW-1:0]   idx_ff, idx_in;
   logic [IW:0]     cnt_ff, cnt_in;
   logic            done_ff, done_in;
   logic            found_ff, found_in;
   logic [IW-1:0]   nxt;

   always_comb begin
      if (idx_ff == IW'(TASK_SLOTS - 1)) begin
         nxt = '0;
      end else begin
         nxt = idx_ff + 1'b1;
      end
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      found_in = found_ff;
      if (start) begin
         busy_in  = 1'b1;
         idx_in   = first;
         cnt_in   = '0;
         found_in = 1'b0;
      end else if (busy_ff) begin
         if (hit[idx_ff]) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            found_in = 1'b1;
         end else if (cnt_ff == (IW+1)'(TASK_SLOTS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            idx_in = nxt;
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         found_ff <= found_in;
      end
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
   end

   assign ctl.start = start;
   assign ctl.done  = done_ff;
   assign ctl.found = found_ff;
   assign index     = idx_ff;

endmodule

// ===== hw/rtl/task_scheduler_with_semaphores_core.sv =====
// Save, teardown, semaphore set and take pass from S_EXEC straight to S_OUT, the result cycle.
// Switch, create and a give on a negative count also pass through S_SCAN and S_FIN; a shared
// slot scanner steps one slot per cycle. Other gives go from S_EXEC straight to S_OUT.
// No new transfer is taken until the last result is out; busy stays high until the
// result cycle ends. Results show for one cycle on rsp_valid; the receiver cannot stall.
// Synchronous reset clears slot use, semaphores and current/previous task.
module task_scheduler_with_semaphores_core #(
   parameter int TASK_SLOTS = tss_pkg::TASK_SLOTS_DEF,
   parameter int SEM_COUNT  = tss_pkg::SEM_COUNT_DEF,
   localparam int IW = $clog2(TASK_SLOTS),
   localparam int SW = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tss_pkg::req_type req_data,
   output logic             rsp_valid,
   output tss_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_SCAN, S_FIN, S_OUT
   } fsm_type;

   fsm_type                 st_ff;
   tss_pkg::req_type        req_ff;
   tss_pkg::rsp_type        rsp_ff;
   logic [TASK_SLOTS-1:0]   used_ff;
   logic [2:0]              tstate_ff [TASK_SLOTS];
   logic [SW-1:0]           won_ff [TASK_SLOTS];
   logic                    cur_v_ff, prev_v_ff;
   logic [IW-1:0]           cur_ff, prev_ff;
   logic signed [15:0]      cnt_ff [SEM_COUNT];
   logic [TASK_SLOTS-1:0]   wait_ff [SEM_COUNT];

   logic                    scan_start;
   logic [IW-1:0]           scan_first;
   logic [TASK_SLOTS-1:0]   hit;
   tss_pkg::scan_ctl_type   sctl;
   logic [IW-1:0]           sidx;

   logic                    sid_ok, ts_ok;
   logic [SW-1:0]           sid;
   logic [IW-1:0]           ts;
   logic signed [15:0]      cnt_cur, cnt_inc, cnt_dec;

   assign sid_ok = ({29'd0, req_ff.sem_id} < SEM_COUNT);
   assign ts_ok  = ({28'd0, req_ff.task_slot} < TASK_SLOTS);
   assign sid    = SW'(req_ff.sem_id);
   assign ts     = IW'(req_ff.task_slot);
   assign cnt_cur = cnt_ff[sid];
   assign cnt_inc = (cnt_cur == tss_pkg::COUNT_MAX) ? cnt_cur : cnt_cur + 16'sd1;
   assign cnt_dec = (cnt_cur == tss_pkg::COUNT_MIN) ? cnt_cur : cnt_cur - 16'sd1;

   always_comb begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
         case (req_ff.func)
            tss_pkg::FUNC_SWITCH:
               hit[i] = used_ff[i] && (tstate_ff[i] == tss_pkg::ST_RUNNABLE);
            tss_pkg::FUNC_CREATE:
               hit[i] = !used_ff[i];
            default:
               hit[i] = wait_ff[sid][i];
         endcase
      end
   end

   always_comb begin
      scan_first = '0;
      if (req_ff.func == tss_pkg::FUNC_SWITCH && cur_v_ff) begin
         scan_first = (cur_ff == IW'(TASK_SLOTS - 1)) ? '0 : cur_ff + 1'b1;
      end
   end

   assign scan_start = (st_ff == S_EXEC) &&
      (req_ff.func == tss_pkg::FUNC_SWITCH || req_ff.func == tss_pkg::FUNC_CREATE ||
       (req_ff.func == tss_pkg::FUNC_SEM_GIVE && sid_ok &&
        !(cur_v_ff && tstate_ff[cur_ff] != tss_pkg::ST_RUNNING) && cnt_cur < 0));

   tss_scan #(.TASK_SLOTS(TASK_SLOTS)) u_scan (
      .clock (clock),
      .reset (reset),
      .start (scan_start),
      .first (scan_first),
      .hit   (hit),
      .ctl   (sctl),
      .index (sidx)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_IDLE;
         used_ff   <= '0;
         cur_v_ff  <= 1'b0;
         prev_v_ff <= 1'b0;
         for (int j = 0; j < SEM_COUNT; j++) begin
            cnt_ff[j]  <= '0;
            wait_ff[j] <= '0;
         end
      end else begin
         case (st_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff <= req_data;
                  st_ff  <= S_EXEC;
               end
            end
            S_EXEC: begin
               rsp_ff <= '0;
               st_ff  <= S_OUT;
               case (req_ff.func)
                  tss_pkg::FUNC_SAVE: begin
                     if (prev_v_ff && used_ff[prev_ff]) begin
                        rsp_ff.slot <= 4'(prev_ff);
                        case (tstate_ff[prev_ff])
                           tss_pkg::ST_RUNNING, tss_pkg::ST_RUNNABLE_TOBE:
                              tstate_ff[prev_ff] <= tss_pkg::ST_RUNNABLE;
                           tss_pkg::ST_WAITING_TOBE:
                              tstate_ff[prev_ff] <= tss_pkg::ST_WAITING;
                           tss_pkg::ST_KILLED: begin
                              used_ff[prev_ff] <= 1'b0;
                              rsp_ff.freed     <= 1'b1;
                           end
                           default: ;
                        endcase
                     end else begin
                        rsp_ff.status <= tss_pkg::STATUS_BAD;
                     end
                     prev_v_ff <= cur_v_ff;
                     prev_ff   <= cur_ff;
                     cur_v_ff  <= 1'b0;
                     cur_ff    <= '0;
                  end
                  tss_pkg::FUNC_SWITCH, tss_pkg::FUNC_CREATE: st_ff <= S_SCAN;
                  tss_pkg::FUNC_TEARDOWN: begin
                     rsp_ff.slot <= req_ff.task_slot;
                     if (!ts_ok || !used_ff[ts]) begin
                        rsp_ff.status <= tss_pkg::STATUS_BAD;
                     end else begin
                        case (tstate_ff[ts])
                           tss_pkg::ST_RUNNABLE: begin
                              used_ff[ts]  <= 1'b0;
                              rsp_ff.freed <= 1'b1;
                           end
                           tss_pkg::ST_RUNNING: tstate_ff[ts] <= tss_pkg::ST_KILLED;
                           tss_pkg::ST_WAITING: begin
                              if (cnt_ff[won_ff[ts]] != tss_pkg::COUNT_MAX) begin
                                 cnt_ff[won_ff[ts]] <= cnt_ff[won_ff[ts]] + 16'sd1;
                              end
                              wait_ff[won_ff[ts]][ts] <= 1'b0;
                              used_ff[ts]  <= 1'b0;
                              rsp_ff.freed <= 1'b1;
                           end
                           default: ;
                        endcase
                     end
                  end
                  tss_pkg::FUNC_SEM_SET: begin
                     if (!sid_ok) begin
                        rsp_ff.status <= tss_pkg::STATUS_BAD;
                     end else begin
                        cnt_ff[sid]  <= 16'(req_ff.init_count);
                        wait_ff[sid] <= '0;
                     end
                  end
                  tss_pkg::FUNC_SEM_TAKE: begin
                     if (!sid_ok || !cur_v_ff) begin
                        rsp_ff.status <= tss_pkg::STATUS_BAD;
                     end else begin
                        rsp_ff.slot <= 4'(cur_ff);
                        cnt_ff[sid] <= cnt_dec;
                        if (cnt_dec < 0) begin
                           wait_ff[sid][cur_ff] <= 1'b1;
                           if (tstate_ff[cur_ff] == tss_pkg::ST_RUNNING) begin
                              won_ff[cur_ff]    <= sid;
                              tstate_ff[cur_ff] <= tss_pkg::ST_WAITING_TOBE;
                           end
                           rsp_ff.blocked <= 1'b1;
                        end
                     end
                  end
                  tss_pkg::FUNC_SEM_GIVE: begin
                     if (!sid_ok ||
                         (cur_v_ff && tstate_ff[cur_ff] != tss_pkg::ST_RUNNING)) begin
                        rsp_ff.status <= tss_pkg::STATUS_BAD;
                     end else if (scan_start) begin
                        st_ff <= S_SCAN;
                     end else begin
                        rsp_ff.status <= tss_pkg::STATUS_NONE;
                        cnt_ff[sid]   <= cnt_inc;
                     end
                  end
                  default: rsp_ff.status <= tss_pkg::STATUS_NONE;
               endcase
            end
            S_SCAN: begin
               if (sctl.done) begin
                  st_ff <= S_FIN;
               end
            end
            S_FIN: begin
               st_ff <= S_OUT;
               case (req_ff.func)
                  tss_pkg::FUNC_SWITCH: begin
                     if (sctl.found) begin
                        tstate_ff[sidx] <= tss_pkg::ST_RUNNING;
                        cur_v_ff        <= 1'b1;
                        cur_ff          <= sidx;
                        rsp_ff.slot     <= 4'(sidx);
                     end else begin
                        cur_v_ff      <= 1'b0;
                        cur_ff        <= '0;
                        rsp_ff.status <= tss_pkg::STATUS_NONE;
                        rsp_ff.idle   <= 1'b1;
                     end
                  end
                  tss_pkg::FUNC_CREATE: begin
                     if (sctl.found) begin
                        used_ff[sidx]   <= 1'b1;
                        tstate_ff[sidx] <= tss_pkg::ST_RUNNABLE;
                        rsp_ff.slot     <= 4'(sidx);
                     end else begin
                        rsp_ff.status <= tss_pkg::STATUS_NONE;
                     end
                  end
                  default: begin
                     cnt_ff[sid] <= cnt_inc;
                     if (sctl.found) begin
                        if (tstate_ff[sidx] == tss_pkg::ST_WAITING) begin
                           tstate_ff[sidx] <= tss_pkg::ST_RUNNABLE;
                        end else if (tstate_ff[sidx] == tss_pkg::ST_WAITING_TOBE) begin
                           tstate_ff[sidx] <= tss_pkg::ST_RUNNABLE_TOBE;
                        end
                        wait_ff[sid][sidx] <= 1'b0;
                        rsp_ff.slot        <= 4'(sidx);
                     end else begin
                        rsp_ff.status <= tss_pkg::STATUS_NONE;
                     end
                  end
               endcase
            end
            S_OUT: st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = (st_ff != S_IDLE);
   assign rsp_valid = (st_ff == S_OUT);
   assign rsp_data  = rsp_ff;

   a_one_shot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result held two cycles");
   a_start_exec: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (st_ff == S_EXEC)) else $error("transfer not taken");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status != 2'd3)) else $error("bad status");
   a_idle_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.idle) |-> !cur_v_ff) else $error("idle with current task");

endmodule

// ===== bench/tb_task_scheduler_with_semaphores_core.sv =====
module tb_task_scheduler_with_semaphores_core;

   localparam int NSLOT = 16;
   localparam int NSEM = 8;
   localparam int FUNC_UNKNOWN = 7;
   localparam int STALL_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   tss_pkg::req_type req_data = '0;
   logic rsp_valid;
   tss_pkg::rsp_type rsp_data;

   task_scheduler_with_semaphores_core u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // scheduler shadow state
   bit slot_busy[NSLOT];
   tss_pkg::task_state_type tstate[NSLOT];
   logic [2:0] wait_sem[NSLOT];
   bit cur_ok, prev_ok;
   logic [3:0] cur_idx, prev_idx;
   logic signed [15:0] sem_val[NSEM];
   logic [15:0] sem_wq[NSEM];

   tss_pkg::req_type pending_reqs[$];
   tss_pkg::rsp_type expected_rsps[$];
   int mismatches = 0;
   int idle_cycles = 0;
   int gap_left = 0;
   bit took = 0;
   bit stim_done = 0;

   function automatic logic signed [15:0] sat16(int v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return -16'sh8000;
      return v[15:0];
   endfunction

   function automatic tss_pkg::rsp_type schedule_step(tss_pkg::req_type r);
      tss_pkg::rsp_type o;
      int b;
      int k;
      bit hit;
      o = '0;
      case (r.func)
         tss_pkg::FUNC_SAVE: begin
            if (prev_ok && slot_busy[prev_idx]) begin
               case (tstate[prev_idx])
                  tss_pkg::ST_RUNNING, tss_pkg::ST_RUNNABLE_TOBE:
                     tstate[prev_idx] = tss_pkg::ST_RUNNABLE;
                  tss_pkg::ST_WAITING_TOBE: tstate[prev_idx] = tss_pkg::ST_WAITING;
                  tss_pkg::ST_KILLED: begin
                     slot_busy[prev_idx] = 0;
                     o.freed = 1;
                  end
                  default: ;
               endcase
               o.slot = prev_idx;
            end else begin
               o.status = tss_pkg::STATUS_BAD;
            end
            prev_ok = cur_ok;
            prev_idx = cur_idx;
            cur_ok = 0;
            cur_idx = 0;
         end
         tss_pkg::FUNC_SWITCH: begin
            b = cur_ok ? (cur_idx + 1) % NSLOT : 0;
            hit = 0;
            for (int i = 0; i < NSLOT && !hit; i++) begin
               k = (b + i) % NSLOT;
               if (slot_busy[k] && tstate[k] == tss_pkg::ST_RUNNABLE) begin
                  tstate[k] = tss_pkg::ST_RUNNING;
                  cur_ok = 1;
                  cur_idx = 4'(k);
                  o.slot = 4'(k);
                  hit = 1;
               end
            end
            if (!hit) begin
               cur_ok = 0;
               cur_idx = 0;
               o.status = tss_pkg::STATUS_NONE;
               o.idle = 1;
            end
         end
         tss_pkg::FUNC_CREATE: begin
            o.status = tss_pkg::STATUS_NONE;
            for (int i = 0; i < NSLOT; i++) begin
               if (!slot_busy[i]) begin
                  slot_busy[i] = 1;
                  tstate[i] = tss_pkg::ST_RUNNABLE;
                  o.slot = 4'(i);
                  o.status = tss_pkg::STATUS_OK;
                  break;
               end
            end
         end
         tss_pkg::FUNC_TEARDOWN: begin
            o.slot = r.task_slot;
            if (!slot_busy[r.task_slot]) begin
               o.status = tss_pkg::STATUS_BAD;
            end else begin
               case (tstate[r.task_slot])
                  tss_pkg::ST_RUNNABLE: begin
                     slot_busy[r.task_slot] = 0;
                     o.freed = 1;
                  end
                  tss_pkg::ST_RUNNING: tstate[r.task_slot] = tss_pkg::ST_KILLED;
                  tss_pkg::ST_WAITING: begin
                     sem_val[wait_sem[r.task_slot]] =
                        sat16(sem_val[wait_sem[r.task_slot]] + 1);
                     sem_wq[wait_sem[r.task_slot]][r.task_slot] = 1'b0;
                     slot_busy[r.task_slot] = 0;
                     o.freed = 1;
                  end
                  default: ;
               endcase
            end
         end
         tss_pkg::FUNC_SEM_SET: begin
            sem_val[r.sem_id] = {8'd0, r.init_count};
            sem_wq[r.sem_id] = '0;
         end
         tss_pkg::FUNC_SEM_TAKE: begin
            if (!cur_ok) begin
               o.status = tss_pkg::STATUS_BAD;
            end else begin
               o.slot = cur_idx;
               sem_val[r.sem_id] = sat16(sem_val[r.sem_id] - 1);
               if (sem_val[r.sem_id] < 0) begin
                  sem_wq[r.sem_id][cur_idx] = 1'b1;
                  if (tstate[cur_idx] == tss_pkg::ST_RUNNING) begin
                     wait_sem[cur_idx] = r.sem_id;
                     tstate[cur_idx] = tss_pkg::ST_WAITING_TOBE;
                  end
                  o.blocked = 1;
               end
            end
         end
         tss_pkg::FUNC_SEM_GIVE: begin
            if (cur_ok && tstate[cur_idx] != tss_pkg::ST_RUNNING) begin
               o.status = tss_pkg::STATUS_BAD;
            end else begin
               o.status = tss_pkg::STATUS_NONE;
               if (sem_val[r.sem_id] < 0) begin
                  for (int i = 0; i < NSLOT; i++) begin
                     if (sem_wq[r.sem_id][i]) begin
                        if (tstate[i] == tss_pkg::ST_WAITING)
                           tstate[i] = tss_pkg::ST_RUNNABLE;
                        else if (tstate[i] == tss_pkg::ST_WAITING_TOBE)
                           tstate[i] = tss_pkg::ST_RUNNABLE_TOBE;
                        sem_wq[r.sem_id][i] = 1'b0;
                        o.slot = 4'(i);
                        o.status = tss_pkg::STATUS_OK;
                        break;
                     end
                  end
               end
               sem_val[r.sem_id] = sat16(sem_val[r.sem_id] + 1);
            end
         end
         default: o.status = tss_pkg::STATUS_NONE;
      endcase
      return o;
   endfunction

   function automatic tss_pkg::req_type mk_req(int f, int ts, int sid, int ic);
      tss_pkg::req_type r;
      r.func = 3'(f);
      r.task_slot = 4'(ts);
      r.sem_id = 3'(sid);
      r.init_count = 8'(ic);
      return r;
   endfunction

   function automatic int pick_func();
      int w;
      w = $urandom_range(99);
      if (w < 15) return tss_pkg::FUNC_CREATE;
      if (w < 35) return tss_pkg::FUNC_SWITCH;
      if (w < 55) return tss_pkg::FUNC_SAVE;
      if (w < 65) return tss_pkg::FUNC_TEARDOWN;
      if (w < 73) return tss_pkg::FUNC_SEM_SET;
      if (w < 85) return tss_pkg::FUNC_SEM_TAKE;
      if (w < 98) return tss_pkg::FUNC_SEM_GIVE;
      return FUNC_UNKNOWN;
   endfunction

   function automatic int pick_gap();
      int w;
      w = $urandom_range(9);
      if (w < 4) return 0;
      if (w < 9) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset && !(start && !took)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_data <= pending_reqs.pop_front();
            start <= 1'b1;
            gap_left <= pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      tss_pkg::rsp_type exp_rsp;
      took <= start && !busy && !reset;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result transfer %p", rsp_data);
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (exp_rsp !== rsp_data) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p actual %p", exp_rsp, rsp_data);
               end
            end
         end
         if (start && !busy)
            expected_rsps.push_back(schedule_step(req_data));
         if (rsp_valid || (start && !busy) || (stim_done && expected_rsps.size() == 0))
            idle_cycles <= 0;
         else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("tb_task_scheduler_with_semaphores_core failed");
            $finish;
         end else
            idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < NSLOT; i++) slot_busy[i] = 0;
      for (int i = 0; i < NSEM; i++) begin
         sem_val[i] = 0;
         sem_wq[i] = '0;
      end
      cur_ok = 0;
      prev_ok = 0;
      cur_idx = 0;
      prev_idx = 0;

      pending_reqs.push_back(mk_req(tss_pkg::FUNC_SAVE, 0, 0, 0));
      pending_reqs.push_back(mk_req(tss_pkg::FUNC_SWITCH, 0, 0, 0));
      pending_reqs.push_back(mk_req(tss_pkg::FUNC_SEM_TAKE, 0, 0, 0));
      pending_reqs.push_back(mk_req(tss_pkg::FUNC_TEARDOWN, 15, 7, 255));
      pending_reqs.push_back(mk_req(tss_pkg::FUNC_SEM_SET, 0, 0, 255));
      pending_reqs.push_back(mk_req(tss_pkg::FUNC_SEM_SET, 0, 7, 0));
      for (int i = 0; i < 17; i++)
         pending_reqs.push_back(mk_req(tss_pkg::FUNC_CREATE, 0, 0, 0));
      pending_reqs.push_back(mk_req(tss_pkg::FUNC_SWITCH, 0, 0, 0));
      pending_reqs.push_back(mk_req(tss_pkg::FUNC_SEM_TAKE, 0, 7, 0));
      pending_reqs.push_back(mk_req(tss_pkg::FUNC_SEM_GIVE, 0, 7, 0));
      pending_reqs.push_back(mk_req(tss_pkg::FUNC_SAVE, 0, 0, 0));
      pending_reqs.push_back(mk_req(tss_pkg::FUNC_SAVE, 0, 0, 0));
      pending_reqs.push_back(mk_req(tss_pkg::FUNC_TEARDOWN, 0, 0, 0));
      pending_reqs.push_back(mk_req(FUNC_UNKNOWN, 15, 7, 255));
      for (int i = 0; i < 620; i++)
         pending_reqs.push_back(mk_req(pick_func(), $urandom_range(15), $urandom_range(7),
            ($urandom_range(3) == 0) ? ($urandom_range(1) ? 255 : 0) : $urandom_range(255)));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (pending_reqs.size() != 0 || start) @(posedge clock);
      stim_done = 1;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("tb_task_scheduler_with_semaphores_core passed");
      else
         $display("tb_task_scheduler_with_semaphores_core failed");
      $finish;
   end

endmodule
